// ===== hdl/lkr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU-K replacer package
// Shared widths, item kinds and status codes.
// ----------------------------------------------------------------------------
package lkr_pkg;
   localparam int FrameDefault = 64;
   localparam int FuncW   = 2;
   localparam int FrameW  = 6;
   localparam int KW      = 4;
   localparam int StatusW = 2;
   localparam int CountW  = 7;

   localparam logic [FuncW-1:0] FUNC_ACCESS = 2'd0;
   localparam logic [FuncW-1:0] FUNC_SETEV  = 2'd1;
   localparam logic [FuncW-1:0] FUNC_EVICT  = 2'd2;
   localparam logic [FuncW-1:0] FUNC_REMOVE = 2'd3;

   localparam logic [StatusW-1:0] ST_OK     = 2'd0;
   localparam logic [StatusW-1:0] ST_EMPTY  = 2'd1;
   localparam logic [StatusW-1:0] ST_PINNED = 2'd2;

   localparam logic [KW-1:0] K_RESET = 4'd2;
endpackage

// ===== hdl/lru_k_frame_replacer.sv =====
// ----------------------------------------------------------------------------
// LRU-K frame replacer
// Victim selection over N_FRAMES frames with history and cache lists.
// ----------------------------------------------------------------------------
// One item at a time. busy is high from the accepting edge until the result
// is out, and start is ignored meanwhile. Items that change the list order
// pass the rank store through one shared compare and update unit, one frame
// per cycle, and each pass walks all N_FRAMES frames.
// Steps per item:
//   - none for evict with nothing evictable and for a frame index out of range;
//   - a read of the frame's own rank and hit count for set evictable, for remove
//     of a pinned or inactive frame, and for an access that leaves the frame in the history list;
//   - that read, then a push pass for the first access of a frame or an unlink pass for remove;
//   - a search pass, then an unlink pass, for evict;
//   - the read, an unlink pass, then a push pass for an access that moves the frame to the front of the
//     cache list.
// The result is on the rsp_ ports with rsp_valid in the first cycle that busy
// is low. The receiver cannot stall the block, and the next item can be taken
// at the edge that ends the result cycle.
module lru_k_frame_replacer #(
   parameter int N_FRAMES = lkr_pkg::FrameDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [lkr_pkg::FuncW-1:0]   req_func,
   input  logic [lkr_pkg::FrameW-1:0]  req_frame,
   input  logic                        req_evictable_flag,
   input  logic                        csr_we,
   input  logic [lkr_pkg::KW-1:0]      csr_wdata,
   output logic                        rsp_valid,
   output logic [lkr_pkg::StatusW-1:0] rsp_status,
   output logic                        rsp_victim_valid,
   output logic [lkr_pkg::FrameW-1:0]  rsp_victim_frame,
   output logic [lkr_pkg::CountW-1:0]  rsp_evictable_count
);
   import lkr_pkg::*;

   localparam int IW = (N_FRAMES > 1) ? $clog2(N_FRAMES) : 1;
   localparam int RW = IW;
   localparam int CW = $clog2(N_FRAMES + 1);
   localparam logic [IW-1:0] LAST = IW'(N_FRAMES - 1);

   localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_DEC = 3'd2, S_SRCH = 3'd3,
                          S_UNL = 3'd4, S_PUSH = 3'd5, S_DONE = 3'd6;

   // per-frame flops
   logic [N_FRAMES-1:0] act_ff, act_in, ev_ff, ev_in, sel_ff, sel_in;
   // hit count and rank stores: one frame per cycle
   logic [KW-1:0] hits_mem [N_FRAMES];
   logic [RW-1:0] rank_mem [N_FRAMES];
   logic [KW-1:0] hits_rd_ff;
   logic [RW-1:0] rank_rd_ff;

   logic [2:0]         state_ff, state_in;
   logic [KW-1:0]      k_ff;
   logic [FuncW-1:0]   func_ff, func_in;
   logic [FrameW-1:0]  frm_ff, frm_in;
   logic [IW-1:0]      f_ff, f_in, best_ff, best_in;
   logic               flag_ff, flag_in, found_ff, found_in, which_ff, which_in;
   logic               rmv_ff, rmv_in, vv_ff, vv_in;
   logic [RW-1:0]      frank_ff, frank_in, bestr_ff, bestr_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [IW-1:0]      idx_q_ff;   // index of rank_rd_ff
   logic               rd_ok_ff, rd_ok_in;
   logic [CW-1:0]      tot_ff, tot_in, hist_ff, hist_in;
   logic [StatusW-1:0] st_ff, st_in;

   logic               res_valid_ff;
   logic [StatusW-1:0] res_status_ff;
   logic               res_vv_ff;
   logic [FrameW-1:0]  res_frame_ff;
   logic [CountW-1:0]  res_count_ff;

   logic               wr_en, hw_en;
   logic [IW-1:0]      wr_a;
   logic [RW-1:0]      wr_d;
   logic [KW-1:0]      hw_d;

   logic [KW-1:0] keff, hits_inc;
   logic [IW-1:0] q, idx_nx;
   logic          in_range, last_q, cand;

   assign keff     = (k_ff < KW'(2)) ? KW'(2) : k_ff;
   assign hits_inc = (hits_rd_ff < keff) ? hits_rd_ff + 1'b1 : hits_rd_ff;
   assign in_range = 32'(req_frame) < 32'(N_FRAMES);
   assign busy     = (state_ff != S_IDLE);
   assign q        = idx_q_ff;
   assign idx_nx   = (idx_ff == LAST) ? idx_ff : idx_ff + 1'b1;
   assign last_q   = rd_ok_ff && (q == LAST);
   assign cand     = rd_ok_ff && act_ff[q] && ev_ff[q] && (sel_ff[q] == which_ff) &&
                     (!found_ff || rank_rd_ff > bestr_ff);

   assign rsp_valid           = res_valid_ff;
   assign rsp_status          = res_status_ff;
   assign rsp_victim_valid    = res_vv_ff;
   assign rsp_victim_frame    = res_frame_ff;
   assign rsp_evictable_count = res_count_ff;

   always_ff @(posedge clock) begin
      rank_rd_ff <= rank_mem[idx_ff];
      hits_rd_ff <= hits_mem[idx_ff];
      if (wr_en) rank_mem[wr_a] <= wr_d;
      if (hw_en) hits_mem[f_ff] <= hw_d;
   end

   // one frame per cycle: lower ranks above the leaving frame, or push to front
   always_comb begin
      wr_en = 1'b0;
      wr_a  = q;
      wr_d  = rank_rd_ff;
      if (rd_ok_ff && state_ff == S_UNL) begin
         if (q != f_ff && act_ff[q] && sel_ff[q] == sel_ff[f_ff] &&
             rank_rd_ff > frank_ff) begin
            wr_en = 1'b1;
            wr_d  = rank_rd_ff - 1'b1;
         end
      end else if (rd_ok_ff && state_ff == S_PUSH) begin
         if (q == f_ff) begin
            wr_en = 1'b1;
            wr_d  = '0;
         end else if (act_ff[q] && sel_ff[q] == which_ff) begin
            wr_en = 1'b1;
            wr_d  = rank_rd_ff + 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff; func_in = func_ff; frm_in = frm_ff; f_in = f_ff;
      flag_in = flag_ff; found_in = found_ff; which_in = which_ff; rmv_in = rmv_ff;
      vv_in = vv_ff; frank_in = frank_ff; best_in = best_ff; bestr_in = bestr_ff;
      idx_in = idx_ff; tot_in = tot_ff; hist_in = hist_ff; st_in = st_ff;
      act_in = act_ff; ev_in = ev_ff; sel_in = sel_ff;
      rd_ok_in = 1'b0;
      hw_en = 1'b0;
      hw_d = hits_inc;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in = req_func; frm_in = req_frame; f_in = IW'(req_frame);
               flag_in = req_evictable_flag; st_in = ST_OK; vv_in = 1'b0;
               found_in = 1'b0; rmv_in = 1'b0; idx_in = '0;
               if (req_func == FUNC_EVICT) begin
                  if (tot_ff == '0) begin
                     st_in = ST_EMPTY; state_in = S_DONE;
                  end else begin
                     which_in = (hist_ff == '0); state_in = S_SRCH;
                  end
               end else if (!in_range) begin
                  state_in = S_DONE;
               end else begin
                  idx_in = IW'(req_frame); state_in = S_RD;
               end
            end
         end
         S_RD: state_in = S_DEC; // fetch own rank and hit count
         S_DEC: begin
            frank_in = rank_rd_ff; idx_in = '0; state_in = S_DONE;
            case (func_ff)
               FUNC_ACCESS: begin
                  hw_en = 1'b1;
                  if (!act_ff[f_ff]) begin
                     hw_d = KW'(1);
                     act_in[f_ff] = 1'b1; sel_in[f_ff] = 1'b0; which_in = 1'b0;
                     state_in = S_PUSH;
                     if (ev_ff[f_ff]) begin
                        tot_in = tot_ff + 1'b1; hist_in = hist_ff + 1'b1;
                     end
                  end else if (sel_ff[f_ff] || hits_inc >= keff) begin
                     if (!sel_ff[f_ff] && ev_ff[f_ff]) hist_in = hist_ff - 1'b1;
                     which_in = 1'b1; state_in = S_UNL;
                  end
               end
               FUNC_SETEV: begin
                  ev_in[f_ff] = flag_ff;
                  if (act_ff[f_ff] && !ev_ff[f_ff] && flag_ff) begin
                     tot_in = tot_ff + 1'b1;
                     if (!sel_ff[f_ff]) hist_in = hist_ff + 1'b1;
                  end else if (act_ff[f_ff] && ev_ff[f_ff] && !flag_ff) begin
                     tot_in = tot_ff - 1'b1;
                     if (!sel_ff[f_ff]) hist_in = hist_ff - 1'b1;
                  end
               end
               FUNC_REMOVE: begin
                  if (act_ff[f_ff]) begin
                     if (ev_ff[f_ff]) begin
                        rmv_in = 1'b1; state_in = S_UNL;
                     end else st_in = ST_PINNED;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_SRCH: begin
            rd_ok_in = !last_q;
            idx_in = idx_nx;
            if (cand) begin
               found_in = 1'b1; best_in = q; bestr_in = rank_rd_ff;
            end
            if (last_q) begin
               idx_in = '0;
               if (cand || found_ff) begin
                  f_in = cand ? q : best_ff;
                  frank_in = cand ? rank_rd_ff : bestr_ff;
                  frm_in = FrameW'(f_in);
                  vv_in = 1'b1; rmv_in = 1'b1; state_in = S_UNL;
               end else begin
                  st_in = ST_EMPTY; state_in = S_DONE;
               end
            end
         end
         S_UNL: begin
            rd_ok_in = !last_q;
            idx_in = idx_nx;
            if (last_q) begin
               idx_in = '0;
               if (rmv_ff) begin
                  act_in[f_ff] = 1'b0; ev_in[f_ff] = 1'b1; sel_in[f_ff] = 1'b0;
                  tot_in = tot_ff - 1'b1;
                  if (!sel_ff[f_ff]) hist_in = hist_ff - 1'b1;
                  state_in = S_DONE;
               end else begin
                  sel_in[f_ff] = 1'b1; state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            rd_ok_in = !last_q;
            idx_in = idx_nx;
            if (last_q) state_in = S_DONE;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; k_ff <= K_RESET;
         act_ff <= '0; ev_ff <= '1; sel_ff <= '0;
         tot_ff <= '0; hist_ff <= '0; res_valid_ff <= 1'b0;
         idx_ff <= '0; rd_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) k_ff <= csr_wdata;
         act_ff <= act_in; ev_ff <= ev_in; sel_ff <= sel_in;
         tot_ff <= tot_in; hist_ff <= hist_in;
         idx_ff <= idx_in; rd_ok_ff <= rd_ok_in;
         res_valid_ff <= (state_ff == S_DONE);
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in; frm_ff <= frm_in; f_ff <= f_in; flag_ff <= flag_in;
      found_ff <= found_in; which_ff <= which_in; rmv_ff <= rmv_in; vv_ff <= vv_in;
      frank_ff <= frank_in; best_ff <= best_in; bestr_ff <= bestr_in;
      st_ff <= st_in; idx_q_ff <= idx_ff;
      if (state_ff == S_DONE) begin
         res_status_ff <= st_ff;
         res_vv_ff <= vv_ff;
         res_frame_ff <= vv_ff ? frm_ff : '0;
         res_count_ff <= CountW'(tot_ff);
      end
   end

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result held");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("busy with result");
   a_hist_le: assert property (@(posedge clock) disable iff (reset)
      hist_ff <= tot_ff) else $error("history count exceeds total");
   a_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_victim_valid |-> rsp_status == ST_OK)
      else $error("victim with error");
endmodule

// ===== bench/tb_lru_k_frame_replacer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU-K frame replacer testbench
// Drives access, set evictable, evict and remove items through the command
// port. A behavioural replica of the frame lists predicts each response, and
// the monitor compares every field. k_distance is written with values from 0 to 15.
// ----------------------------------------------------------------------------
module tb_lru_k_frame_replacer;
   import lkr_pkg::*;

   localparam int NF = 64;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [FuncW-1:0]    req_func = FUNC_ACCESS;
   logic [FrameW-1:0]   req_frame = '0;
   logic                req_evictable_flag = 1'b0;
   logic                csr_we = 1'b0;
   logic [KW-1:0]       csr_wdata = '0;
   logic                rsp_valid;
   logic [StatusW-1:0]  rsp_status;
   logic                rsp_victim_valid;
   logic [FrameW-1:0]   rsp_victim_frame;
   logic [CountW-1:0]   rsp_evictable_count;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic               victim_valid;
      logic [FrameW-1:0]  victim_frame;
      logic [CountW-1:0]  evictable_count;
   } rsp_type;

   rsp_type pending_rsp[$];
   bit   failed = 0;

   // replica of the frame table
   bit         fr_active[NF];
   bit         fr_evictable[NF];
   int         fr_hits[NF];
   bit         fr_in_cache[NF];
   int         fr_rank[NF];
   int         n_evictable;
   int         n_evictable_hist;
   logic [KW-1:0] k_reg;

   lru_k_frame_replacer #(.N_FRAMES(NF)) dut (.*);

   always #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("== FAIL ==");
      $finish;
   end

   function automatic void table_reset();
      for (int i = 0; i < NF; i++) begin
         fr_active[i] = 0; fr_evictable[i] = 1; fr_hits[i] = 0;
         fr_in_cache[i] = 0; fr_rank[i] = 0;
      end
      n_evictable = 0;
      n_evictable_hist = 0;
      k_reg = K_RESET;
   endfunction

   function automatic void push_newest(int f, bit cache);
      for (int i = 0; i < NF; i++)
         if (i != f && fr_active[i] && fr_in_cache[i] == cache) fr_rank[i]++;
      fr_in_cache[f] = cache;
      fr_rank[f] = 0;
   endfunction

   function automatic void unlink(int f);
      for (int i = 0; i < NF; i++)
         if (i != f && fr_active[i] && fr_in_cache[i] == fr_in_cache[f] &&
             fr_rank[i] > fr_rank[f]) fr_rank[i]--;
   endfunction

   function automatic void drop(int f);
      unlink(f);
      if (fr_evictable[f]) begin
         n_evictable--;
         if (!fr_in_cache[f]) n_evictable_hist--;
      end
      fr_active[f] = 0; fr_evictable[f] = 1; fr_hits[f] = 0;
      fr_in_cache[f] = 0; fr_rank[f] = 0;
   endfunction

   function automatic rsp_type predict_replacement(logic [FuncW-1:0] fn, int f, bit flag);
      rsp_type r;
      int   k;
      bit   was, now, found, pick;
      int   best;
      r = '0;
      k = (k_reg < 2) ? 2 : int'(k_reg);
      case (fn)
         FUNC_ACCESS: begin
            if (!fr_active[f]) begin
               fr_active[f] = 1;
               fr_hits[f] = 1;
               push_newest(f, 0);
               if (fr_evictable[f]) begin
                  n_evictable++; n_evictable_hist++;
               end
            end else begin
               if (fr_hits[f] < k) fr_hits[f]++;
               if (!fr_in_cache[f]) begin
                  if (fr_hits[f] >= k) begin
                     unlink(f);
                     push_newest(f, 1);
                     if (fr_evictable[f]) n_evictable_hist--;
                  end
               end else begin
                  unlink(f);
                  push_newest(f, 1);
               end
            end
         end
         FUNC_SETEV: begin
            was = fr_active[f] && fr_evictable[f];
            now = fr_active[f] && flag;
            fr_evictable[f] = flag;
            if (!was && now) begin
               n_evictable++;
               if (!fr_in_cache[f]) n_evictable_hist++;
            end else if (was && !now) begin
               n_evictable--;
               if (!fr_in_cache[f]) n_evictable_hist--;
            end
         end
         FUNC_EVICT: begin
            found = 0;
            best = 0;
            if (n_evictable != 0) begin
               pick = (n_evictable_hist > 0) ? 1'b0 : 1'b1;
               for (int i = 0; i < NF; i++)
                  if (fr_active[i] && fr_evictable[i] && fr_in_cache[i] == pick)
                     if (!found || fr_rank[i] > fr_rank[best]) begin
                        best = i; found = 1;
                     end
            end
            if (found) begin
               drop(best);
               r.victim_valid = 1'b1;
               r.victim_frame = best[FrameW-1:0];
            end else r.status = ST_EMPTY;
         end
         default: begin
            if (fr_active[f]) begin
               if (fr_evictable[f]) drop(f);
               else r.status = ST_PINNED;
            end
         end
      endcase
      r.evictable_count = n_evictable[CountW-1:0];
      return r;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("response with nothing outstanding");
            failed = 1;
         end else begin
            exp_r = pending_rsp.pop_front();
            if (rsp_status !== exp_r.status) begin
               $error("status exp %0d got %0d", exp_r.status, rsp_status); failed = 1;
            end
            if (rsp_victim_valid !== exp_r.victim_valid) begin
               $error("victim_valid exp %0d got %0d", exp_r.victim_valid,
                      rsp_victim_valid); failed = 1;
            end
            if (rsp_victim_frame !== exp_r.victim_frame) begin
               $error("victim_frame exp %0d got %0d", exp_r.victim_frame,
                      rsp_victim_frame); failed = 1;
            end
            if (rsp_evictable_count !== exp_r.evictable_count) begin
               $error("evictable_count exp %0d got %0d", exp_r.evictable_count,
                      rsp_evictable_count); failed = 1;
            end
         end
      end
   end

   int burst_left = 0;

   // send one item, with bursty gaps between items
   task automatic send_item(logic [FuncW-1:0] fn, int f, bit flag);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      burst_left--;
      req_func = fn;
      req_frame = f[FrameW-1:0];
      req_evictable_flag = flag;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_rsp.push_back(predict_replacement(fn, f, flag));
      @(negedge clock);
      start = 1'b0;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      while (pending_rsp.size() != 0 && guard < 10000) begin
         @(negedge clock);
         guard++;
      end
      repeat (2 * NF + 8) @(negedge clock);
   endtask

   task automatic write_k(logic [KW-1:0] v);
      drain();
      csr_we = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      k_reg = v;
   endtask

   task automatic test_directed();
      send_item(FUNC_EVICT, 0, 1'b0);           // nothing evictable
      send_item(FUNC_REMOVE, 63, 1'b0);         // remove inactive frame
      send_item(FUNC_SETEV, 5, 1'b0);           // flag stored on inactive frame
      send_item(FUNC_ACCESS, 5, 1'b0);
      send_item(FUNC_ACCESS, 0, 1'b0);
      send_item(FUNC_ACCESS, 63, 1'b1);
      send_item(FUNC_ACCESS, 0, 1'b0);          // moves to cache list
      send_item(FUNC_ACCESS, 0, 1'b0);          // hit count saturates
      send_item(FUNC_REMOVE, 5, 1'b1);          // pinned
      send_item(FUNC_SETEV, 63, 1'b0);
      send_item(FUNC_SETEV, 63, 1'b1);
      send_item(FUNC_EVICT, 42, 1'b1);
      send_item(FUNC_SETEV, 5, 1'b1);
      send_item(FUNC_EVICT, 0, 1'b0);
      send_item(FUNC_EVICT, 0, 1'b0);
      send_item(FUNC_EVICT, 0, 1'b0);
      send_item(FUNC_REMOVE, 0, 1'b0);
   endtask

   task automatic test_small_and_lowered_k();
      write_k(4'd0);                            // below two acts as two
      for (int i = 0; i < 3; i++) send_item(FUNC_ACCESS, 10, 1'b0);
      write_k(4'd15);
      for (int i = 0; i < 18; i++) send_item(FUNC_ACCESS, 20, 1'b0);
      send_item(FUNC_ACCESS, 21, 1'b0);
      for (int i = 0; i < 4; i++) send_item(FUNC_ACCESS, 22, 1'b0);
      write_k(4'd3);                            // frame 22 moves at next access
      send_item(FUNC_ACCESS, 22, 1'b0);
      send_item(FUNC_EVICT, 0, 1'b0);
      write_k(4'd1);
      send_item(FUNC_ACCESS, 21, 1'b0);
   endtask

   task automatic random_phase(int n, int span);
      int r, f;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         f = (span == NF) ? $urandom_range(0, NF - 1) : $urandom_range(0, span - 1);
         if (r < 45) send_item(FUNC_ACCESS, f, 1'($urandom_range(0, 1)));
         else if (r < 65) send_item(FUNC_SETEV, f, $urandom_range(0, 3) != 0);
         else if (r < 85) send_item(FUNC_EVICT, int'($urandom_range(0, 63)),
                                    1'($urandom_range(0, 1)));
         else send_item(FUNC_REMOVE, f, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_random();
      logic [KW-1:0] ks[5] = '{4'd2, 4'd15, 4'd3, 4'd7, 4'd1};
      foreach (ks[j]) begin
         write_k(ks[j]);
         random_phase(200, 12);                 // few frames: deep hit counts
         random_phase(100, NF);
      end
   endtask

   initial begin
      table_reset();
      repeat (2) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_small_and_lowered_k();
      test_random();
      drain();
      if (!failed && pending_rsp.size() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end
endmodule
